[src/prp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_pkg: shared constants, types and functions
// Fixed-point formats, CORDIC arctangent table, sequencer states and the
// saturation helpers used by the point rotator.
// ----------------------------------------------------------------------------
package prp_pkg;

  localparam int COORD_BITS   = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int FIELD_W = 16;
  localparam int MAG_W   = 16;
  localparam int PHASE_W = 15;

  localparam int DATA_W    = (COORD_BITS + 18 > 36) ? COORD_BITS + 18 : 36;
  localparam int STEP_W    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int TAB_IDX_W = 5;

  localparam int MUL_W  = (DATA_W - 15 > 16) ? DATA_W - 15 : 16;
  localparam int GAIN_W = 31;
  localparam int PROD_W = MUL_W + GAIN_W;
  localparam int Q_W    = PROD_W - 29;

  localparam logic signed [GAIN_W-1:0]  INV_GAIN    = 31'sh26DD3B6A;
  localparam logic signed [DATA_W-1:0]  PI_Q30      = DATA_W'(64'sd3373259426);
  localparam logic signed [FIELD_W-1:0] HALF_PI_Q13 = 16'sd12868;

  localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam longint COORD_MIN = -COORD_MAX - 64'sd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_GX,
    ST_GY,
    ST_VSET,
    ST_VEC,
    ST_GM,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    G_IDLE,
    G_LO,
    G_HI,
    G_SUM
  } gain_state_t;

  typedef struct packed {
    logic load;
    logic vector_mode;
  } cordic_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_st_t;

  function automatic logic [31:0] atan_q30(input logic [TAB_IDX_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h3243F6A8;
      5'd1:    r = 32'h1DAC6705;
      5'd2:    r = 32'h0FADBAFC;
      5'd3:    r = 32'h07F56EA6;
      5'd4:    r = 32'h03FEAB76;
      5'd5:    r = 32'h01FFD55B;
      5'd6:    r = 32'h00FFFAAA;
      5'd7:    r = 32'h007FFF55;
      5'd8:    r = 32'h003FFFEA;
      5'd9:    r = 32'h001FFFFD;
      5'd10:   r = 32'h000FFFFF;
      5'd11:   r = 32'h0007FFFF;
      5'd12:   r = 32'h0003FFFF;
      5'd13:   r = 32'h0001FFFF;
      5'd14:   r = 32'h0000FFFF;
      5'd15:   r = 32'h00007FFF;
      5'd16:   r = 32'h00003FFF;
      5'd17:   r = 32'h00001FFF;
      5'd18:   r = 32'h00000FFF;
      5'd19:   r = 32'h000007FF;
      5'd20:   r = 32'h000003FF;
      5'd21:   r = 32'h000001FF;
      5'd22:   r = 32'h000000FF;
      5'd23:   r = 32'h0000007F;
      5'd24:   r = 32'h0000003F;
      5'd25:   r = 32'h0000001F;
      5'd26:   r = 32'h0000000F;
      5'd27:   r = 32'h00000008;
      5'd28:   r = 32'h00000004;
      5'd29:   r = 32'h00000002;
      5'd30:   r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [Q_W-1:0] v
  );
    logic signed [Q_W-1:0] hi;
    logic signed [Q_W-1:0] lo;
    logic signed [COORD_BITS-1:0] r;
    hi = Q_W'(COORD_MAX);
    lo = Q_W'(COORD_MIN);
    if (v > hi) begin
      r = COORD_BITS'(COORD_MAX);
    end else if (v < lo) begin
      r = COORD_BITS'(COORD_MIN);
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [FIELD_W-1:0] coord_field(
    input logic signed [COORD_BITS-1:0] v
  );
    logic signed [63:0] t;
    t = 64'(v);
    return t[FIELD_W-1:0];
  endfunction

endpackage

[src/prp_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_req_if: request channel
// Carries one load or rotate item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface prp_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  func;
  logic signed [prp_pkg::FIELD_W-1:0]    new_x;
  logic signed [prp_pkg::FIELD_W-1:0]    new_y;
  logic signed [prp_pkg::FIELD_W-1:0]    angle;

  modport source (output valid, func, new_x, new_y, angle, input ready);
  modport sink (input valid, func, new_x, new_y, angle, output ready);
endinterface

[src/prp_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_rsp_if: response channel
// Carries the point and its polar form with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface prp_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [prp_pkg::FIELD_W-1:0]    x_out;
  logic signed [prp_pkg::FIELD_W-1:0]    y_out;
  logic        [prp_pkg::MAG_W-1:0]      magnitude;
  logic signed [prp_pkg::PHASE_W-1:0]    phase;

  modport source (output valid, x_out, y_out, magnitude, phase, input ready);
  modport sink (input valid, x_out, y_out, magnitude, phase, output ready);
endinterface

[src/prp_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_cordic: iterative CORDIC engine
// One shift-add step per cycle in rotation or vectoring mode, shared by the
// rotate and polar passes.
// ----------------------------------------------------------------------------
module prp_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  prp_pkg::cordic_ctl_t                ctl,
  input  logic signed [prp_pkg::DATA_W-1:0]   x0,
  input  logic signed [prp_pkg::DATA_W-1:0]   y0,
  input  logic signed [prp_pkg::DATA_W-1:0]   z0,
  output prp_pkg::cordic_st_t                 st,
  output logic signed [prp_pkg::DATA_W-1:0]   x,
  output logic signed [prp_pkg::DATA_W-1:0]   y,
  output logic signed [prp_pkg::DATA_W-1:0]   z
);

  logic [prp_pkg::STEP_W-1:0]          idx;
  logic                                mode;
  logic                                busy;
  logic                                done;
  logic                                up;
  logic signed [prp_pkg::DATA_W-1:0]   dx;
  logic signed [prp_pkg::DATA_W-1:0]   dy;
  logic signed [prp_pkg::DATA_W-1:0]   at;
  logic signed [prp_pkg::DATA_W-1:0]   x_next;
  logic signed [prp_pkg::DATA_W-1:0]   y_next;
  logic signed [prp_pkg::DATA_W-1:0]   z_next;

  always_comb begin
    dx = y >>> idx;
    dy = x >>> idx;
    at = prp_pkg::DATA_W'(prp_pkg::atan_q30(prp_pkg::TAB_IDX_W'(idx)));
    up = mode ? !y[prp_pkg::DATA_W-1] : z[prp_pkg::DATA_W-1];
    x_next = up ? x + dx : x - dx;
    y_next = up ? y - dy : y + dy;
    z_next = up ? z + at : z - at;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
      mode <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.load) begin
        busy <= 1'b1;
        idx  <= '0;
        mode <= ctl.vector_mode;
      end else if (busy) begin
        idx <= idx + prp_pkg::STEP_W'(1);
        if (idx == prp_pkg::STEP_W'(prp_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= x0;
      y <= y0;
      z <= z0;
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  assign st.busy = busy;
  assign st.done = done;

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  assert property (p_done_after_busy)
    else $error("cordic done without a running pass");

endmodule

[src/prp_gain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_gain: CORDIC gain correction and rounding
// Multiplies by 1/K in two partial products on one multiplier, then rounds
// from Q.26 to Q.12.
// ----------------------------------------------------------------------------
module prp_gain (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [prp_pkg::DATA_W-1:0]   v,
  output logic                                done,
  output logic signed [prp_pkg::Q_W-1:0]      q
);

  prp_pkg::gain_state_t                gst;
  prp_pkg::gain_state_t                gst_next;
  logic signed [prp_pkg::DATA_W-1:0]   vreg;
  logic signed [prp_pkg::PROD_W-1:0]   prod;
  logic signed [prp_pkg::PROD_W-1:0]   acc;
  logic signed [prp_pkg::MUL_W-1:0]    lo_op;
  logic signed [prp_pkg::MUL_W-1:0]    hi_op;
  logic signed [prp_pkg::MUL_W-1:0]    op;
  logic signed [prp_pkg::PROD_W-1:0]   mul;
  logic signed [prp_pkg::PROD_W-1:0]   sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      gst <= prp_pkg::G_IDLE;
    end else begin
      gst <= gst_next;
    end
  end

  always_comb begin
    gst_next = gst;
    case (gst)
      prp_pkg::G_IDLE: begin
        if (start) begin
          gst_next = prp_pkg::G_LO;
        end
      end
      prp_pkg::G_LO:  gst_next = prp_pkg::G_HI;
      prp_pkg::G_HI:  gst_next = prp_pkg::G_SUM;
      prp_pkg::G_SUM: gst_next = prp_pkg::G_IDLE;
      default:        gst_next = prp_pkg::G_IDLE;
    endcase
  end

  always_comb begin
    lo_op = prp_pkg::MUL_W'({1'b0, vreg[14:0]});
    hi_op = prp_pkg::MUL_W'(vreg >>> 15);
    op    = (gst == prp_pkg::G_LO) ? lo_op : hi_op;
    mul   = op * prp_pkg::INV_GAIN;
    sum   = prod + acc + prp_pkg::PROD_W'(64'sd1 <<< 28);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (gst == prp_pkg::G_SUM);
    end
  end

  always_ff @(posedge clk) begin
    if (gst == prp_pkg::G_IDLE && start) begin
      vreg <= v;
    end
    if (gst == prp_pkg::G_LO || gst == prp_pkg::G_HI) begin
      prod <= mul;
    end
    if (gst == prp_pkg::G_HI) begin
      acc <= prod >>> 15;
    end
    if (gst == prp_pkg::G_SUM) begin
      q <= sum[prp_pkg::PROD_W-1:29];
    end
  end

endmodule

[src/point_rotate_polar.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_rotate_polar: 2D point rotator with polar readout
// Holds one signed Q3.12 point. A request item with func = 0 loads the point
// from new_x/new_y; with func = 1 it turns the stored point clockwise by
// angle (Q2.13 radians), saturating the result. Each request gives one
// response item: the point, its magnitude (Q4.12) and phase (Q1.13).
// Requests and responses use valid/ready; an item moves when both are high.
// One item at a time: ready is high only while idle. A shared CORDIC
// engine (one step per cycle) and a shared gain multiplier do the work in order:
//   load:   vectoring pass, magnitude gain, then the response
//   rotate: rotation pass, x gain, y gain, vectoring pass, magnitude gain, then the response
// The next request is taken the cycle after the response is taken.
// The response holds steady while the receiver stalls.
// Reset clears the point to the origin and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module point_rotate_polar (
  input  logic        clk,
  input  logic        rst,
  prp_req_if.sink     req,
  prp_rsp_if.source   rsp
);

  prp_pkg::state_t                        state;
  prp_pkg::state_t                        state_next;
  prp_pkg::cordic_ctl_t                   core_ctl;
  prp_pkg::cordic_st_t                    core_st;
  logic signed [prp_pkg::DATA_W-1:0]      core_x;
  logic signed [prp_pkg::DATA_W-1:0]      core_y;
  logic signed [prp_pkg::DATA_W-1:0]      core_z;
  logic signed [prp_pkg::DATA_W-1:0]      x0;
  logic signed [prp_pkg::DATA_W-1:0]      y0;
  logic signed [prp_pkg::DATA_W-1:0]      z0;
  logic                                   gain_start;
  logic                                   gain_sel_y;
  logic                                   gain_done;
  logic signed [prp_pkg::DATA_W-1:0]      gain_v;
  logic signed [prp_pkg::Q_W-1:0]         gq;

  logic signed [prp_pkg::COORD_BITS-1:0]  x_pos;
  logic signed [prp_pkg::COORD_BITS-1:0]  y_pos;
  logic        [prp_pkg::MAG_W-1:0]       mag_r;
  logic signed [prp_pkg::PHASE_W-1:0]     phase_r;

  logic signed [prp_pkg::DATA_W-1:0]      xs;
  logic signed [prp_pkg::DATA_W-1:0]      ys;
  logic signed [prp_pkg::DATA_W-1:0]      a17;
  logic                                   big_pos;
  logic                                   big_neg;
  logic                                   flip;
  logic signed [prp_pkg::DATA_W-1:0]      zr;
  logic signed [prp_pkg::DATA_W-1:0]      half_ext;
  logic        [prp_pkg::MAG_W-1:0]       mag_next;
  logic signed [prp_pkg::PHASE_W-1:0]     phase_next;

  prp_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .ctl (core_ctl),
    .x0  (x0),
    .y0  (y0),
    .z0  (z0),
    .st  (core_st),
    .x   (core_x),
    .y   (core_y),
    .z   (core_z)
  );

  prp_gain u_gain (
    .clk   (clk),
    .rst   (rst),
    .start (gain_start),
    .v     (gain_v),
    .done  (gain_done),
    .q     (gq)
  );

  assign gain_v = gain_sel_y ? core_y : core_x;

  // CORDIC seed: rotation from the request angle, vectoring from the point
  always_comb begin
    xs      = prp_pkg::DATA_W'(x_pos) <<< 14;
    ys      = prp_pkg::DATA_W'(y_pos) <<< 14;
    a17     = prp_pkg::DATA_W'(req.angle) <<< 17;
    big_pos = req.angle > prp_pkg::HALF_PI_Q13;
    big_neg = req.angle < -prp_pkg::HALF_PI_Q13;
    if (state == prp_pkg::ST_IDLE) begin
      flip = big_pos || big_neg;
      if (big_pos) begin
        z0 = prp_pkg::PI_Q30 - a17;
      end else if (big_neg) begin
        z0 = -a17 - prp_pkg::PI_Q30;
      end else begin
        z0 = -a17;
      end
    end else begin
      flip = x_pos[prp_pkg::COORD_BITS-1];
      z0   = '0;
    end
    x0 = flip ? -xs : xs;
    y0 = flip ? -ys : ys;
  end

  // polar results from the vectoring pass
  always_comb begin
    half_ext = prp_pkg::DATA_W'(prp_pkg::HALF_PI_Q13);
    zr       = (core_z + prp_pkg::DATA_W'(65536)) >>> 17;
    if (gq < 0) begin
      mag_next = '0;
    end else if (gq > prp_pkg::Q_W'(65535)) begin
      mag_next = '1;
    end else begin
      mag_next = gq[prp_pkg::MAG_W-1:0];
    end
    if (x_pos == '0) begin
      if (y_pos > 0) begin
        phase_next = prp_pkg::PHASE_W'(prp_pkg::HALF_PI_Q13);
      end else if (y_pos < 0) begin
        phase_next = prp_pkg::PHASE_W'(-prp_pkg::HALF_PI_Q13);
      end else begin
        phase_next = '0;
      end
    end else if (y_pos == '0) begin
      phase_next = '0;
    end else if (zr > half_ext) begin
      phase_next = prp_pkg::PHASE_W'(prp_pkg::HALF_PI_Q13);
    end else if (zr < -half_ext) begin
      phase_next = prp_pkg::PHASE_W'(-prp_pkg::HALF_PI_Q13);
    end else begin
      phase_next = zr[prp_pkg::PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next           = state;
    core_ctl.load        = 1'b0;
    core_ctl.vector_mode = 1'b0;
    gain_start           = 1'b0;
    gain_sel_y           = 1'b0;
    req.ready            = 1'b0;
    rsp.valid            = 1'b0;
    case (state)
      prp_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.func) begin
            core_ctl.load = 1'b1;
            state_next    = prp_pkg::ST_ROT;
          end else begin
            state_next = prp_pkg::ST_VSET;
          end
        end
      end
      prp_pkg::ST_ROT: begin
        if (core_st.done) begin
          gain_start = 1'b1;
          state_next = prp_pkg::ST_GX;
        end
      end
      prp_pkg::ST_GX: begin
        if (gain_done) begin
          gain_start = 1'b1;
          gain_sel_y = 1'b1;
          state_next = prp_pkg::ST_GY;
        end
      end
      prp_pkg::ST_GY: begin
        if (gain_done) begin
          state_next = prp_pkg::ST_VSET;
        end
      end
      prp_pkg::ST_VSET: begin
        core_ctl.load        = 1'b1;
        core_ctl.vector_mode = 1'b1;
        state_next           = prp_pkg::ST_VEC;
      end
      prp_pkg::ST_VEC: begin
        if (core_st.done) begin
          gain_start = 1'b1;
          state_next = prp_pkg::ST_GM;
        end
      end
      prp_pkg::ST_GM: begin
        if (gain_done) begin
          state_next = prp_pkg::ST_OUT;
        end
      end
      prp_pkg::ST_OUT: begin
        rsp.valid = 1'b1;
        if (rsp.ready) begin
          state_next = prp_pkg::ST_IDLE;
        end
      end
      default: state_next = prp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_pos <= '0;
      y_pos <= '0;
    end else begin
      if (state == prp_pkg::ST_IDLE && req.valid && !req.func) begin
        x_pos <= prp_pkg::sat_coord(prp_pkg::Q_W'(req.new_x));
        y_pos <= prp_pkg::sat_coord(prp_pkg::Q_W'(req.new_y));
      end
      if (state == prp_pkg::ST_GX && gain_done) begin
        x_pos <= prp_pkg::sat_coord(gq);
      end
      if (state == prp_pkg::ST_GY && gain_done) begin
        y_pos <= prp_pkg::sat_coord(gq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == prp_pkg::ST_GM && gain_done) begin
      mag_r   <= mag_next;
      phase_r <= phase_next;
    end
  end

  assign rsp.x_out     = prp_pkg::coord_field(x_pos);
  assign rsp.y_out     = prp_pkg::coord_field(y_pos);
  assign rsp.magnitude = mag_r;
  assign rsp.phase     = phase_r;

  property p_core_done_state;
    @(posedge clk) disable iff (rst)
      core_st.done |-> (state == prp_pkg::ST_ROT || state == prp_pkg::ST_VEC);
  endproperty
  assert property (p_core_done_state)
    else $error("cordic pass ended outside a CORDIC wait state");

  property p_gain_done_state;
    @(posedge clk) disable iff (rst)
      gain_done |->
        (state == prp_pkg::ST_GX || state == prp_pkg::ST_GY || state == prp_pkg::ST_GM);
  endproperty
  assert property (p_gain_done_state)
    else $error("gain result arrived outside a gain wait state");

  property p_no_overlap;
    @(posedge clk) disable iff (rst) !(req.ready && rsp.valid);
  endproperty
  assert property (p_no_overlap)
    else $error("request taken while a response is pending");

  property p_phase_range;
    @(posedge clk) disable iff (rst)
      rsp.valid |-> (phase_r <= prp_pkg::PHASE_W'(prp_pkg::HALF_PI_Q13) &&
                     phase_r >= prp_pkg::PHASE_W'(-prp_pkg::HALF_PI_Q13));
  endproperty
  assert property (p_phase_range)
    else $error("phase outside a quarter turn");

  property p_idle_after_output;
    @(posedge clk) disable iff (rst) (rsp.valid && rsp.ready) |=> req.ready;
  endproperty
  assert property (p_idle_after_output)
    else $error("not idle after the response item left");

endmodule
